// ----- rtl/twt_pkg.sv -----
`default_nettype none

package twt_pkg;

  localparam int CLK_W    = 32;
  localparam int PSC_W    = 16;
  localparam int FREQ_W   = 13;
  localparam int DSR_W    = 29;
  localparam int DUR_W    = 8;
  localparam int WORD_W   = 16;
  localparam int RELOAD_W = 16;
  localparam int CMP_W    = 15;
  localparam int QUO_W    = 32;

  localparam int TWT_RELOAD_BITS = 16;

  localparam logic [CLK_W-1:0] CLOCK_RESET    = 32'd72000000;
  localparam logic [PSC_W-1:0] PRESCALE_RESET = 16'd72;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_END = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;

  localparam logic CFG_CLOCK    = 1'b0;
  localparam logic CFG_PRESCALE = 1'b1;

  localparam logic [3:0] NOTE_MAX   = 4'd11;
  localparam logic [3:0] OCTAVE_TOP = 4'd8;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  duration;
    logic [CLK_W-1:0]  dvd;
    logic [DSR_W-1:0]  dsr;
    logic [CLK_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } twt_item_t;

  function automatic logic [FREQ_W-1:0] top_octave_hz(input logic [3:0] note);
    logic [FREQ_W-1:0] hz;
    unique case (note)
      4'd0:    hz = 13'd4186;
      4'd1:    hz = 13'd4435;
      4'd2:    hz = 13'd4699;
      4'd3:    hz = 13'd4978;
      4'd4:    hz = 13'd5274;
      4'd5:    hz = 13'd5588;
      4'd6:    hz = 13'd5920;
      4'd7:    hz = 13'd6272;
      4'd8:    hz = 13'd6645;
      4'd9:    hz = 13'd7040;
      4'd10:   hz = 13'd7459;
      4'd11:   hz = 13'd7902;
      default: hz = '0;
    endcase
    return hz;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/twt_front.sv -----
`default_nettype none

module twt_front
  import twt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [WORD_W-1:0] tone_word,
  input  wire logic [CLK_W-1:0]  clock_hz,
  input  wire logic [PSC_W-1:0]  prescaler,
  output twt_item_t              item_out
);

  logic [3:0]        note;
  logic [3:0]        octave;
  logic [FREQ_W-1:0] freq_c;
  logic [DSR_W-1:0]  dsr_c;
  logic [1:0]        status_c;
  logic              valid_r;
  twt_item_t         item_r;

  assign note   = tone_word[3:0];
  assign octave = tone_word[7:4];
  assign freq_c = top_octave_hz(note) >> (OCTAVE_TOP - octave);
  assign dsr_c  = {{(DSR_W-FREQ_W){1'b0}}, freq_c} * {{(DSR_W-PSC_W){1'b0}}, prescaler};

  always_comb begin
    if (tone_word == '0) begin
      status_c = ST_END;
    end else if (note > NOTE_MAX || octave > OCTAVE_TOP) begin
      status_c = ST_BAD;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    item_r.valid    <= 1'b0;
    item_r.status   <= status_c;
    item_r.freq     <= freq_c;
    item_r.duration <= tone_word[15:8];
    item_r.dvd      <= clock_hz;
    item_r.dsr      <= dsr_c;
    item_r.rem      <= '0;
    item_r.quo      <= '0;
  end

  always_comb begin
    item_out       = item_r;
    item_out.valid = valid_r;
  end

endmodule

`default_nettype wire

// ----- rtl/twt_div_cell.sv -----
`default_nettype none

module twt_div_cell
  import twt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire twt_item_t item_in,
  output twt_item_t      item_out
);

  logic [CLK_W:0] trial;
  logic [CLK_W:0] dsr_ext;
  logic           fits;
  logic [CLK_W:0] diff;
  logic           valid_r;
  twt_item_t      item_r;

  // one quotient bit per cell, restoring step
  assign trial   = {item_in.rem, item_in.dvd[CLK_W-1]};
  assign dsr_ext = {{(CLK_W+1-DSR_W){1'b0}}, item_in.dsr};
  assign fits    = trial >= dsr_ext;
  assign diff    = trial - dsr_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r.valid    <= 1'b0;
    item_r.status   <= item_in.status;
    item_r.freq     <= item_in.freq;
    item_r.duration <= item_in.duration;
    item_r.dsr      <= item_in.dsr;
    item_r.dvd      <= {item_in.dvd[CLK_W-2:0], 1'b0};
    item_r.rem      <= fits ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
    item_r.quo      <= {item_in.quo[QUO_W-2:0], fits};
  end

  always_comb begin
    item_out       = item_r;
    item_out.valid = valid_r;
  end

endmodule

`default_nettype wire

// ----- rtl/twt_finish.sv -----
`default_nettype none

module twt_finish
  import twt_pkg::*;
#(
  parameter int RELOAD_BITS = TWT_RELOAD_BITS
)
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire twt_item_t           item_in,
  output logic                     out_valid,
  output logic                     out_tone_on,
  output logic [FREQ_W-1:0]        out_tone_freq_hz,
  output logic [RELOAD_W-1:0]      out_reload_value,
  output logic [CMP_W-1:0]         out_compare_value,
  output logic [DUR_W-1:0]         out_duration_ticks,
  output logic [1:0]               out_status
);

  localparam logic [QUO_W:0] MAX_RELOAD = (33'd1 << RELOAD_BITS) - 33'd1;

  logic [QUO_W-1:0] q_minus;
  logic [QUO_W-1:0] reload_c;
  logic [1:0]       status_c;
  logic             on_c;

  logic                valid_r;
  logic                on_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [RELOAD_W-1:0] reload_r;
  logic [CMP_W-1:0]    cmp_r;
  logic [DUR_W-1:0]    dur_r;
  logic [1:0]          status_r;

  assign q_minus = item_in.quo - 32'd1;

  always_comb begin
    on_c     = 1'b1;
    status_c = ST_OK;
    reload_c = q_minus;
    if (item_in.status != ST_OK) begin
      on_c     = 1'b0;
      status_c = item_in.status;
      reload_c = '0;
    end else if (item_in.quo == '0) begin
      status_c = ST_SAT;
      reload_c = '0;
    end else if ({1'b0, q_minus} > MAX_RELOAD) begin
      status_c = ST_SAT;
      reload_c = MAX_RELOAD[QUO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    on_r     <= on_c;
    freq_r   <= on_c ? item_in.freq : '0;
    reload_r <= reload_c[RELOAD_W-1:0];
    cmp_r    <= reload_c[CMP_W:1];
    dur_r    <= on_c ? item_in.duration : '0;
    status_r <= status_c;
  end

  assign out_valid          = valid_r;
  assign out_tone_on        = on_r;
  assign out_tone_freq_hz   = freq_r;
  assign out_reload_value   = reload_r;
  assign out_compare_value  = cmp_r;
  assign out_duration_ticks = dur_r;
  assign out_status         = status_r;

endmodule

`default_nettype wire

// ----- rtl/tone_word_timer_setup_unit.sv -----
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | start, busy          | in_tone_word
// out      | out_valid (strobe)   | out_tone_on, out_tone_freq_hz, out_reload_value,
//          |                      | out_compare_value, out_duration_ticks, out_status
// cfg      | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// one word accepted every cycle while busy is low
// pipeline: decode and multiply stage, 32 divider cells (one quotient bit each), output stage
// busy is high only during reset and the cycle after it; cfg_ready is always high
// synchronous active-low reset clears the valid bits and reloads both registers
// the receiver cannot stall, results are strobed for one cycle
`default_nettype none

module tone_word_timer_setup_unit
  import twt_pkg::*;
#(
  parameter int RELOAD_BITS = TWT_RELOAD_BITS
)
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [WORD_W-1:0]   in_tone_word,
  output logic                     out_valid,
  output logic                     out_tone_on,
  output logic [FREQ_W-1:0]        out_tone_freq_hz,
  output logic [RELOAD_W-1:0]      out_reload_value,
  output logic [CMP_W-1:0]         out_compare_value,
  output logic [DUR_W-1:0]         out_duration_ticks,
  output logic [1:0]               out_status,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [CLK_W-1:0]    cfg_data
);

  localparam int LATENCY = QUO_W + 2;

  logic             busy_r;
  logic [CLK_W-1:0] clock_hz_r;
  logic [PSC_W-1:0] prescaler_r;
  logic             accept;
  twt_item_t        chain [QUO_W+1];

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      clock_hz_r  <= CLOCK_RESET;
      prescaler_r <= PRESCALE_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CLOCK:    clock_hz_r  <= cfg_data;
          CFG_PRESCALE: prescaler_r <= cfg_data[PSC_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  twt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .tone_word (in_tone_word),
    .clock_hz  (clock_hz_r),
    .prescaler (prescaler_r),
    .item_out  (chain[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    twt_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .item_in  (chain[k]),
      .item_out (chain[k+1])
    );
  end

  twt_finish #(
    .RELOAD_BITS (RELOAD_BITS)
  ) u_finish (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_in            (chain[QUO_W]),
    .out_valid          (out_valid),
    .out_tone_on        (out_tone_on),
    .out_tone_freq_hz   (out_tone_freq_hz),
    .out_reload_value   (out_reload_value),
    .out_compare_value  (out_compare_value),
    .out_duration_ticks (out_duration_ticks),
    .out_status         (out_status)
  );

`ifndef SYNTHESIS
  a_result_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a word");

  a_off_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tone_on) |->
      (out_tone_freq_hz == '0 && out_reload_value == '0 && out_compare_value == '0 &&
       out_duration_ticks == '0))
    else $error("tone off with non-zero fields");

  a_off_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tone_on == (out_status == ST_OK || out_status == ST_SAT)))
    else $error("tone_on disagrees with status");
`endif

endmodule

`default_nettype wire

// ----- tb/twt_checker.sv -----
`default_nettype none

module twt_checker
  import twt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [WORD_W-1:0]   in_tone_word,
  input  wire logic                out_valid,
  input  wire logic                out_tone_on,
  input  wire logic [FREQ_W-1:0]   out_tone_freq_hz,
  input  wire logic [RELOAD_W-1:0] out_reload_value,
  input  wire logic [CMP_W-1:0]    out_compare_value,
  input  wire logic [DUR_W-1:0]    out_duration_ticks,
  input  wire logic [1:0]          out_status,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [CLK_W-1:0]    cfg_data,
  output int                       fails,
  output int                       pending,
  output int                       checked,
  output int                       saturated
);

  typedef struct packed {
    logic              on;
    logic [FREQ_W-1:0] freq;
    logic [RELOAD_W-1:0] reload;
    logic [CMP_W-1:0]  cmp;
    logic [DUR_W-1:0]  dur;
    logic [1:0]        status;
  } tone_setting_t;

  localparam logic [FREQ_W-1:0] TOP_HZ [12] = '{
    13'd4186, 13'd4435, 13'd4699, 13'd4978, 13'd5274, 13'd5588,
    13'd5920, 13'd6272, 13'd6645, 13'd7040, 13'd7459, 13'd7902
  };

  logic [CLK_W-1:0] clock_reg;
  logic [PSC_W-1:0] prescale_reg;
  tone_setting_t    tone_queue[$];
  tone_setting_t    want;
  tone_setting_t    got;
  int               fail_cnt = 0;
  int               checked_cnt = 0;
  int               sat_cnt = 0;

  assign fails     = fail_cnt;
  assign pending   = tone_queue.size();
  assign checked   = checked_cnt;
  assign saturated = sat_cnt;

  function automatic tone_setting_t tone_setup_for(input logic [WORD_W-1:0] w);
    tone_setting_t s;
    logic [3:0]    note;
    logic [3:0]    octave;
    logic [63:0]   freq;
    logic [63:0]   divisor;
    logic [63:0]   quotient;
    logic [63:0]   reload;
    logic [63:0]   ceiling;
    s = '0;
    note = w[3:0];
    octave = w[7:4];
    ceiling = (64'd1 << TWT_RELOAD_BITS) - 64'd1;
    reload = '0;
    if (w == '0) begin
      s.status = ST_END;
    end else if (note > NOTE_MAX || octave > OCTAVE_TOP) begin
      s.status = ST_BAD;
    end else begin
      freq = 64'(TOP_HZ[note] >> (4'd8 - octave));
      divisor = freq * 64'(prescale_reg);
      s.status = ST_OK;
      if (divisor == '0) begin
        reload = ceiling;
        s.status = ST_SAT;
      end else begin
        quotient = 64'(clock_reg) / divisor;
        if (quotient == '0) begin
          reload = '0;
          s.status = ST_SAT;
        end else if (quotient - 64'd1 > ceiling) begin
          reload = ceiling;
          s.status = ST_SAT;
        end else begin
          reload = quotient - 64'd1;
        end
      end
      s.on = 1'b1;
      s.freq = freq[FREQ_W-1:0];
      s.reload = reload[RELOAD_W-1:0];
      s.cmp = reload[CMP_W:1];
      s.dur = w[15:8];
    end
    return s;
  endfunction

  task automatic compare_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clock_reg <= CLOCK_RESET;
      prescale_reg <= PRESCALE_RESET;
      tone_queue.delete();
    end else begin
      if (out_valid) begin
        if (tone_queue.size() == 0) begin
          $error("result word with no tone word outstanding");
          fail_cnt++;
        end else begin
          want = tone_queue.pop_front();
          got = '{out_tone_on, out_tone_freq_hz, out_reload_value, out_compare_value,
                  out_duration_ticks, out_status};
          compare_field("tone_on", want.on, got.on);
          compare_field("tone_freq_hz", want.freq, got.freq);
          compare_field("reload_value", want.reload, got.reload);
          compare_field("compare_value", want.cmp, got.cmp);
          compare_field("duration_ticks", want.dur, got.dur);
          compare_field("status", want.status, got.status);
          checked_cnt++;
        end
      end
      if (start && !busy) begin
        want = tone_setup_for(in_tone_word);
        if (want.status == ST_SAT) sat_cnt++;
        tone_queue.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLOCK) clock_reg <= cfg_data;
        else prescale_reg <= cfg_data[PSC_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_tone_word_timer_setup_unit.sv -----
`default_nettype none

module tb_tone_word_timer_setup_unit;
  import twt_pkg::*;

  localparam int PHASES = 6;
  localparam int RANDOM_WORDS = 155;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [WORD_W-1:0]   in_tone_word;
  logic                out_valid;
  logic                out_tone_on;
  logic [FREQ_W-1:0]   out_tone_freq_hz;
  logic [RELOAD_W-1:0] out_reload_value;
  logic [CMP_W-1:0]    out_compare_value;
  logic [DUR_W-1:0]    out_duration_ticks;
  logic [1:0]          out_status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [CLK_W-1:0]    cfg_data;

  int fails;
  int pending;
  int checked;
  int saturated;
  int idle_pct;

  logic [CLK_W-1:0]  clock_sets [PHASES];
  logic [PSC_W-1:0]  prescale_sets [PHASES];
  int                idle_sets [PHASES] = '{0, 48, 0, 22, 48, 0};
  logic [WORD_W-1:0] directed [11] = '{
    16'h0000, 16'hFFFF, 16'h00FB, 16'h009B, 16'h000C, 16'h0100,
    16'h8000, 16'hFF80, 16'h01FF, 16'h008B, 16'h7F0F
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tone_word_timer_setup_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_tone_word       (in_tone_word),
    .out_valid          (out_valid),
    .out_tone_on        (out_tone_on),
    .out_tone_freq_hz   (out_tone_freq_hz),
    .out_reload_value   (out_reload_value),
    .out_compare_value  (out_compare_value),
    .out_duration_ticks (out_duration_ticks),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  twt_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_tone_word       (in_tone_word),
    .out_valid          (out_valid),
    .out_tone_on        (out_tone_on),
    .out_tone_freq_hz   (out_tone_freq_hz),
    .out_reload_value   (out_reload_value),
    .out_compare_value  (out_compare_value),
    .out_duration_ticks (out_duration_ticks),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fails              (fails),
    .pending            (pending),
    .checked            (checked),
    .saturated          (saturated)
  );

  function automatic logic [WORD_W-1:0] melody_word();
    int                pick;
    logic [WORD_W-1:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 8) w = '0;
    else if (pick < 20) w = WORD_W'($urandom);
    else w = {8'($urandom), 4'($urandom_range(0, 8)), 4'($urandom_range(0, 11))};
    return w;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w);
    start <= 1'b1;
    in_tone_word <= w;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_tone_word <= WORD_W'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [CLK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  initial begin
    #(12 * 200000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_tone_word = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CLOCK;
    cfg_data = '0;
    idle_pct = 0;
    clock_sets = '{CLOCK_RESET, 32'hFFFF_FFFF, 32'd0, 32'd1,
                   CLK_W'($urandom_range(1000000, 200000000)), CLK_W'($urandom)};
    prescale_sets = '{PRESCALE_RESET, 16'd1, 16'hFFFF, 16'd0,
                      PSC_W'($urandom_range(1, 300)), PSC_W'($urandom)};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait (pending == 0);
        @(negedge clk);
        write_reg(CFG_CLOCK, clock_sets[phase]);
        write_reg(CFG_PRESCALE, {16'($urandom), prescale_sets[phase]});
        cfg_valid <= 1'b0;
      end
      idle_pct = idle_sets[phase];
      if (phase == 0) begin
        foreach (directed[i]) send_word(directed[i]);
        for (int n = 0; n < 12; n++) send_word({8'(n * 21 + 3), 4'(n % 9), 4'(n)});
      end
      repeat (RANDOM_WORDS) send_word(melody_word());
      if (start) start <= 1'b0;
    end
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("%0d tone words checked under %0d clock and prescaler settings", checked, PHASES);
    $display("%0d of them gave a clamped reload", saturated);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
